[src/rmoc_pkg.sv]
`timescale 1ns / 1ps

package rmoc_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    localparam int SCORE_W = 32;
    localparam int SHIFT_W = 16;
    localparam int RANGE_W = 15;

    localparam int THR_W = 16;
    localparam int WLEN_W = 7;
    localparam int WARM_W = 7;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP    = 2'd2;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 96;

    // control of the cell row
    typedef struct packed {
        logic load;
        logic count;
        logic qual;
        logic shift;
    } t_cell_ctl;

endpackage

[src/rmoc_cell.sv]
`timescale 1ns / 1ps

module rmoc_cell #(
    parameter int N   = rmoc_pkg::WINDOW_MAX_DEF,
    parameter int IDX = 0,
    parameter int LW  = $clog2(N + 1)
) (
    input  logic                               i_clk,
    input  rmoc_pkg::t_cell_ctl                i_ctl,
    input  logic                               i_wr,
    input  logic signed [rmoc_pkg::SCORE_W-1:0] i_wdata,
    input  logic [LW-1:0]                      i_fill,
    input  logic [LW-1:0]                      i_rank,
    input  logic signed [rmoc_pkg::SCORE_W-1:0] i_c,
    input  logic                               i_a,
    input  logic                               i_m,
    output logic signed [rmoc_pkg::SCORE_W-1:0] o_c,
    output logic                               o_a,
    output logic                               o_m
);

    logic signed [rmoc_pkg::SCORE_W-1:0] r_s;
    logic signed [rmoc_pkg::SCORE_W-1:0] r_c;
    logic                                r_a;
    logic                                r_m;
    logic [LW-1:0]                       r_less;
    logic [LW-1:0]                       r_le;
    logic                                w_self;

    assign w_self = LW'(IDX) < i_fill;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_s <= i_wdata;
        end
        if (i_ctl.load) begin
            r_c    <= r_s;
            r_a    <= w_self;
            r_less <= '0;
            r_le   <= '0;
        end else if (i_ctl.count) begin
            if (r_a && (r_c < r_s)) begin
                r_less <= r_less + LW'(1);
            end
            if (r_a && (r_c <= r_s)) begin
                r_le <= r_le + LW'(1);
            end
            r_c <= i_c;
            r_a <= i_a;
        end else if (i_ctl.qual) begin
            r_m <= w_self && (r_less <= i_rank) && (i_rank < r_le);
        end else if (i_ctl.shift) begin
            r_c <= i_c;
            r_m <= i_m;
        end
    end

    assign o_c = r_c;
    assign o_a = r_a;
    assign o_m = r_m;

endmodule

[src/running_median_outlier_check.sv]
`timescale 1ns / 1ps

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  score, shift_x, shift_y
// m_axis    out  m_axis_tvalid / m_axis_tready  frame_valid, median, x/y range
// cfg       in   i_cfg_we                       threshold, window, warmup
//
// a transaction runs these steps from acceptance to result:
// load, one full rotation of the cell row to rank every entry, a qualify step, a shift
// of the row until a cell at the median rank reaches the end, a multiply, a compare
// s_axis_tready is high only in idle, which starts in the cycle the result is loaded;
// a stall on m_axis holds the compare step while the output register is full
// reset (synchronous, active low) clears counters and ranges; cell scores have no reset

module running_median_outlier_check #(
    parameter int WINDOW_MAX = rmoc_pkg::WINDOW_MAX_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // score[31:0], shift_x[47:32], shift_y[63:48]
    input  logic [rmoc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // frame_valid[0], median_score[32:1], min_x_so_far[48:33],
    // max_x_so_far[63:49], min_y_so_far[79:64], max_y_so_far[94:80], zero[95]
    output logic [rmoc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [rmoc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rmoc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int N  = WINDOW_MAX;
    localparam int LW = $clog2(N + 1);
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = (LW > rmoc_pkg::WLEN_W) ? LW : rmoc_pkg::WLEN_W;
    localparam int SW = rmoc_pkg::SCORE_W;
    localparam int HW = rmoc_pkg::SHIFT_W;
    localparam int RW = rmoc_pkg::RANGE_W;
    localparam int PW = SW + rmoc_pkg::THR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COUNT,
        ST_QUAL,
        ST_PICK,
        ST_MUL,
        ST_DONE
    } t_state;

    t_state r_state;

    logic [rmoc_pkg::THR_W-1:0]  r_thr;
    logic [rmoc_pkg::WLEN_W-1:0] r_wlen;
    logic [rmoc_pkg::WARM_W-1:0] r_warm;

    logic [IW-1:0] r_wr_idx;
    logic [LW-1:0] r_fill;
    logic [IW-1:0] r_cnt;

    logic signed [SW-1:0] r_score;
    logic signed [HW-1:0] r_sx;
    logic signed [HW-1:0] r_sy;
    logic signed [SW-1:0] r_med;
    logic [SW:0]          r_diff;
    logic [PW-1:0]        r_prod;
    logic                 r_pos;

    logic signed [HW-1:0] r_min_x;
    logic [RW-1:0]        r_max_x;
    logic signed [HW-1:0] r_min_y;
    logic [RW-1:0]        r_max_y;

    logic                            r_out_valid;
    logic [rmoc_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [CW-1:0] w_wlen_ext;
    logic [LW-1:0] w_len;
    logic [LW-1:0] w_wi_eff;
    logic [LW-1:0] w_wi_inc;
    logic [IW-1:0] n_wr_idx;
    logic [LW-1:0] w_fill_inc;
    logic [LW-1:0] n_fill;
    logic          w_accept;
    logic          w_last_m;
    logic signed [SW:0] w_diff_s;
    logic          w_valid;
    logic          w_out_free;

    logic signed [HW-1:0] n_min_x;
    logic [RW-1:0]        n_max_x;
    logic signed [HW-1:0] n_min_y;
    logic [RW-1:0]        n_max_y;

    rmoc_pkg::t_cell_ctl w_ctl;

    logic signed [SW-1:0] w_c [N];
    logic                 w_a [N];
    logic                 w_m [N];

    // effective window length, ring pointer and fill level update
    always_comb begin
        w_wlen_ext = CW'(r_wlen);
        if (w_wlen_ext == '0) begin
            w_len = LW'(1);
        end else if (w_wlen_ext > CW'(N)) begin
            w_len = LW'(N);
        end else begin
            w_len = LW'(w_wlen_ext);
        end
        w_wi_eff = (LW'(r_wr_idx) >= w_len) ? '0 : LW'(r_wr_idx);
        w_wi_inc = w_wi_eff + LW'(1);
        n_wr_idx = (w_wi_inc >= w_len) ? '0 : IW'(w_wi_inc);
        w_fill_inc = (r_fill < w_len) ? (r_fill + LW'(1)) : r_fill;
        n_fill = (w_fill_inc > w_len) ? w_len : w_fill_inc;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_last_m = w_m[N-1];

    always_comb begin
        w_ctl.load  = (r_state == ST_LOAD);
        w_ctl.count = (r_state == ST_COUNT);
        w_ctl.qual  = (r_state == ST_QUAL);
        w_ctl.shift = (r_state == ST_PICK) && !w_last_m;
    end

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_cell
            localparam int PREV = (k == 0) ? (N - 1) : (k - 1);
            rmoc_cell #(
                .N   (N),
                .IDX (k),
                .LW  (LW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_wr    (w_accept && (w_wi_eff == LW'(k))),
                .i_wdata (s_axis_tdata[SW-1:0]),
                .i_fill  (r_fill),
                .i_rank  (r_fill >> 1),
                .i_c     (w_c[PREV]),
                .i_a     (w_a[PREV]),
                .i_m     (w_m[PREV]),
                .o_c     (w_c[k]),
                .o_a     (w_a[k]),
                .o_m     (w_m[k])
            );
        end
    endgenerate

    assign w_diff_s = {r_med[SW-1], r_med} - {r_score[SW-1], r_score};

    always_comb begin
        w_valid = (CW'(r_fill) < CW'(r_warm)) ||
                  (r_pos && ({{(PW-SW-9){1'b0}}, r_diff, 8'b0} < r_prod));
        n_min_x = r_min_x;
        n_max_x = r_max_x;
        n_min_y = r_min_y;
        n_max_y = r_max_y;
        if (w_valid) begin
            if (r_sx < r_min_x) begin
                n_min_x = r_sx;
            end
            if (r_sx > $signed({1'b0, r_max_x})) begin
                n_max_x = RW'(r_sx);
            end
            if (r_sy < r_min_y) begin
                n_min_y = r_sy;
            end
            if (r_sy > $signed({1'b0, r_max_y})) begin
                n_max_y = RW'(r_sy);
            end
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thr       <= rmoc_pkg::THR_W'(128);
            r_wlen      <= rmoc_pkg::WLEN_W'(32);
            r_warm      <= rmoc_pkg::WARM_W'(10);
            r_wr_idx    <= '0;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_min_x     <= '0;
            r_max_x     <= '0;
            r_min_y     <= '0;
            r_max_y     <= '0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
            r_score     <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_med       <= '0;
            r_diff      <= '0;
            r_prod      <= '0;
            r_pos       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rmoc_pkg::CFG_THRESHOLD: r_thr  <= i_cfg_wdata;
                    rmoc_pkg::CFG_WINDOW:    r_wlen <= i_cfg_wdata[rmoc_pkg::WLEN_W-1:0];
                    rmoc_pkg::CFG_WARMUP:    r_warm <= i_cfg_wdata[rmoc_pkg::WARM_W-1:0];
                    default: ;
                endcase
            end

            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_score  <= s_axis_tdata[SW-1:0];
                        r_sx     <= s_axis_tdata[SW+HW-1:SW];
                        r_sy     <= s_axis_tdata[SW+2*HW-1:SW+HW];
                        r_wr_idx <= n_wr_idx;
                        r_fill   <= n_fill;
                        r_state  <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= ST_COUNT;
                end
                ST_COUNT: begin
                    r_cnt <= r_cnt + IW'(1);
                    if (r_cnt == IW'(N - 1)) begin
                        r_state <= ST_QUAL;
                    end
                end
                ST_QUAL: begin
                    r_state <= ST_PICK;
                end
                ST_PICK: begin
                    if (w_last_m) begin
                        r_med   <= w_c[N-1];
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_diff  <= w_diff_s[SW] ? (SW+1)'(-w_diff_s) : (SW+1)'(w_diff_s);
                    r_prod  <= PW'(r_thr) * PW'($unsigned(r_med));
                    r_pos   <= !r_med[SW-1] && (r_med != '0);
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_min_x     <= n_min_x;
                        r_max_x     <= n_max_x;
                        r_min_y     <= n_min_y;
                        r_max_y     <= n_max_y;
                        r_out_data  <= {1'b0, n_max_y, n_min_y, n_max_x, n_min_x,
                                        r_med, w_valid};
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
